FILE: sv/circle_packing_overlap_gradient_step_macros.svh
// assertion shorthands used by the top rtl file
`ifndef CIRCLE_PACKING_OVERLAP_GRADIENT_STEP_MACROS_SVH
`define CIRCLE_PACKING_OVERLAP_GRADIENT_STEP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define CPOG_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define CPOG_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/cpog_pkg.sv
// ----------------------------------------------------------------------------
// cpog_pkg
// shared constants and types of the circle packing gradient step block
// ----------------------------------------------------------------------------
package cpog_pkg;

	localparam int MAX_CIRCLES = 64;
	localparam int IDX_W = $clog2(MAX_CIRCLES);
	localparam int CNT_W = $clog2(MAX_CIRCLES + 1);

	localparam int POS_W = 20;
	localparam int RAD_W = 17;
	localparam int STEP_W = 17;
	localparam int PUSH_W = 48;
	localparam int EN_W = 32;
	localparam int DROP_W = 33;
	localparam int MUL_W = 34;
	localparam int PROD_W = 2 * MUL_W;
	localparam int SQ_W = 64;
	localparam int ROOT_W = 32;
	localparam int NUM_W = 48;
	localparam int DEN_W = 32;

	localparam int ONE_Q16 = 65536;
	localparam logic [EN_W-1:0] START_TOTAL = 32'd6553600;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_RUN = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLR,
		S_ROW_RD,
		S_ROW_LD,
		S_PAIR_RD,
		S_PAIR_LD,
		S_MUL_XX,
		S_MUL_YY,
		S_SQRT_GO,
		S_SQRT_WAIT,
		S_DEPTH,
		S_ENERGY,
		S_MUL_PX,
		S_MUL_PY,
		S_ACC,
		S_ROW_WB,
		S_MV_RD,
		S_MV_LD,
		S_MV_SHIFT,
		S_MV_MXX,
		S_MV_MYY,
		S_MV_SQRT_GO,
		S_MV_SQRT_WAIT,
		S_MV_MULX,
		S_MV_DIVX_GO,
		S_MV_DIVX_WAIT,
		S_MV_MULY,
		S_MV_DIVY_GO,
		S_MV_DIVY_WAIT,
		S_MV_OUT
	} state_t;

	typedef struct packed {
		logic done;
		logic [ROOT_W-1:0] root;
	} sqrt_rsp_t;

	typedef struct packed {
		logic done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

FILE: sv/cpog_sqrt.sv
// ----------------------------------------------------------------------------
// cpog_sqrt
// floor square root of a 64-bit value, two radicand bits per cycle
// ----------------------------------------------------------------------------
module cpog_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [cpog_pkg::SQ_W-1:0] arg,
	output cpog_pkg::sqrt_rsp_t rsp
);
	import cpog_pkg::*;

	localparam int ITER = SQ_W / 2;
	localparam int CW = $clog2(ITER);

	logic run_q;
	logic done_q;
	logic [CW-1:0] cnt_q;
	logic [SQ_W-1:0] rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [ROOT_W+3:0] rem_sh;
	logic [ROOT_W+3:0] trial;
	logic fits;

	always_comb begin
		rem_sh = {rem_q, rad_q[SQ_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		fits = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(ITER - 1)) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= arg;
			rem_q <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q <= {rad_q[SQ_W-3:0], 2'b00};
			if (fits) begin
				rem_q <= (ROOT_W+2)'(rem_sh - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[ROOT_W+1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

FILE: sv/cpog_div.sv
// ----------------------------------------------------------------------------
// cpog_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cpog_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [cpog_pkg::NUM_W-1:0] num,
	input  logic [cpog_pkg::DEN_W-1:0] den,
	output cpog_pkg::div_rsp_t rsp
);
	import cpog_pkg::*;

	localparam int CW = $clog2(NUM_W);

	logic run_q;
	logic done_q;
	logic [CW-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;

	logic [DEN_W:0] rem_sh;
	logic fits;

	always_comb begin
		rem_sh = {rem_q, num_q[NUM_W-1]};
		fits = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(NUM_W - 1)) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= DEN_W'(rem_sh - {1'b0, den_q});
			end else begin
				rem_q <= rem_sh[DEN_W-1:0];
			end
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;

endmodule

FILE: sv/circle_packing_overlap_gradient_step.sv
// ----------------------------------------------------------------------------
// circle_packing_overlap_gradient_step
// overlap energy and gradient descent step for circles in a unit container
// ----------------------------------------------------------------------------
// a write item is stored in the cycle it is accepted and gives no result
// a run clears the push and energy of every circle, sums the wall and pair
// overlaps through the single square root unit, then moves each circle with a
// push, halving it to fit if needed, and uses the divider once per axis; the
// first result comes after the energy pass
// throughput: one item at a time, busy stays high for the whole run
// results are strobed by valid for one cycle each; the receiver cannot stall
// reset: circle_count goes to 1, previous total to 100.0, the circle store is
// undefined until written
`include "circle_packing_overlap_gradient_step_macros.svh"

module circle_packing_overlap_gradient_step (
	input  logic clk,
	input  logic arst_n,
	// command side
	input  logic start,
	output logic busy,
	input  logic func,
	input  logic [5:0] index,
	input  logic signed [19:0] pos_x,
	input  logic signed [19:0] pos_y,
	input  logic [16:0] radius,
	input  logic [16:0] step,
	// configuration
	input  logic cfg_we,
	input  logic [6:0] cfg_data,
	// results
	output logic valid,
	output logic [5:0] circle_index,
	output logic signed [19:0] new_x,
	output logic signed [19:0] new_y,
	output logic [31:0] circle_energy,
	output logic [31:0] total_energy,
	output logic signed [32:0] energy_drop,
	output logic last
);
	import cpog_pkg::*;

	localparam int CIRC_W = RAD_W + 2 * POS_W;
	localparam int ACC_W = EN_W + 2 * PUSH_W;
	localparam int D_W = POS_W + 1;
	localparam int DEP_W = MUL_W + 2;
	localparam int Q_W = STEP_W + 1;
	localparam int PS_W = POS_W + 2;
	localparam int T_W = PUSH_W + 8;

	// ---------------------------------------------------------------- helpers
	function automatic logic [PUSH_W-1:0] sat_push(input logic [PUSH_W-1:0] a,
	                                               input logic [T_W-1:0] b);
		logic signed [T_W-1:0] s;
		s = $signed({{(T_W-PUSH_W){a[PUSH_W-1]}}, a}) + $signed(b);
		if (s > $signed(T_W'({1'b0, {(PUSH_W-1){1'b1}}})))
			return {1'b0, {(PUSH_W-1){1'b1}}};
		else if (s < $signed({{(T_W-PUSH_W+1){1'b1}}, {(PUSH_W-1){1'b0}}}))
			return {1'b1, {(PUSH_W-1){1'b0}}};
		else
			return s[PUSH_W-1:0];
	endfunction

	function automatic logic [EN_W-1:0] sat_add32(input logic [EN_W-1:0] a,
	                                              input logic [EN_W-1:0] b);
		logic [EN_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[EN_W] ? {EN_W{1'b1}} : s[EN_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] move_pos(input logic [POS_W-1:0] c,
	                                              input logic neg,
	                                              input logic [Q_W-1:0] q);
		logic signed [PS_W-1:0] v;
		logic signed [PS_W-1:0] d;
		d = $signed({{(PS_W-Q_W){1'b0}}, q});
		v = $signed({{(PS_W-POS_W){c[POS_W-1]}}, c});
		v = neg ? (v - d) : (v + d);
		if (v > $signed(PS_W'({1'b0, {(POS_W-1){1'b1}}})))
			return {1'b0, {(POS_W-1){1'b1}}};
		else if (v < $signed({{(PS_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}}))
			return {1'b1, {(POS_W-1){1'b0}}};
		else
			return v[POS_W-1:0];
	endfunction

	// ---------------------------------------------------------------- state
	state_t state_q, state_d;

	logic [6:0] count_q;
	logic [IDX_W-1:0] lastidx_q;
	logic [IDX_W-1:0] i_q, j_q;
	logic pair_q;
	logic [STEP_W-1:0] step_q;
	logic [EN_W-1:0] total_q, prev_total_q;
	logic [DROP_W-1:0] drop_q;

	// circle i, circle j and pair working values
	logic [POS_W-1:0] xi_q, yi_q;
	logic [RAD_W-1:0] ri_q, rj_q;
	logic signed [D_W-1:0] dx_q, dy_q;
	logic [PUSH_W-1:0] pxi_q, pyi_q, pxj_q, pyj_q;
	logic [EN_W-1:0] eni_q, enj_q, e_q;
	logic [SQ_W-1:0] sq_q;
	logic [ROOT_W-1:0] dist_q;
	logic neg_q;
	logic [T_W-1:0] tx_q;

	// move working values
	logic [POS_W-1:0] cx_q, cy_q;
	logic [RAD_W-1:0] cr_q;
	logic [EN_W-1:0] mven_q;
	logic [PUSH_W-1:0] ax_q, ay_q;
	logic sgnx_q, sgny_q;
	logic [ROOT_W-1:0] len_q;

	// shared multiplier
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;

	// memories
	logic [CIRC_W-1:0] circ_mem [MAX_CIRCLES];
	logic [ACC_W-1:0] acc_mem [MAX_CIRCLES];
	logic [CIRC_W-1:0] circ_rd_q;
	logic [ACC_W-1:0] acc_rd_q;
	logic circ_we, acc_we;
	logic [IDX_W-1:0] circ_wa, acc_wa, rd_addr;
	logic [CIRC_W-1:0] circ_wd;
	logic [ACC_W-1:0] acc_wd;

	// iterative units
	logic sqrt_start, div_start;
	logic [SQ_W-1:0] sqrt_arg;
	logic [NUM_W-1:0] div_num;
	sqrt_rsp_t sqrt_rsp;
	div_rsp_t div_rsp;

	// combinational values
	logic accept, run_go, write_go;
	logic [CNT_W-1:0] n_eff;
	logic signed [DEP_W-1:0] depth;
	logic [T_W-1:0] ty;
	logic [PUSH_W-1:0] new_pxi, new_pyi, new_pxj, new_pyj;
	logic [EN_W-1:0] new_eni, new_enj, new_total;
	logic [PUSH_W-1:0] px_rd, py_rd;
	logic [POS_W-1:0] xj_rd, yj_rd;

	assign accept = start && !busy;
	assign run_go = accept && (func == FUNC_RUN);
	assign write_go = accept && (func == FUNC_WRITE) &&
	                  ({1'b0, index} < 7'(MAX_CIRCLES));
	assign busy = (state_q != S_IDLE);

	// circle count clamp: zero acts as one, large values as the maximum
	always_comb begin
		if (count_q == 7'd0)
			n_eff = CNT_W'(1);
		else if (count_q > 7'(MAX_CIRCLES))
			n_eff = CNT_W'(MAX_CIRCLES);
		else
			n_eff = CNT_W'(count_q);
	end

	// depth of overlap: container depth or pair depth, negative means overlap
	always_comb begin
		if (pair_q)
			depth = $signed({{(DEP_W-ROOT_W){1'b0}}, dist_q})
			      - $signed({{(DEP_W-RAD_W){1'b0}}, ri_q})
			      - $signed({{(DEP_W-RAD_W){1'b0}}, rj_q});
		else
			depth = $signed(DEP_W'(ONE_Q16))
			      - $signed({{(DEP_W-ROOT_W){1'b0}}, dist_q})
			      - $signed({{(DEP_W-RAD_W){1'b0}}, ri_q});
	end

	// accumulation, with saturation after every add
	always_comb begin
		ty = prod_q[T_W-1:0];
		new_pxi = sat_push(pxi_q, tx_q);
		new_pyi = sat_push(pyi_q, ty);
		new_pxj = sat_push(pxj_q, T_W'(-$signed(tx_q)));
		new_pyj = sat_push(pyj_q, T_W'(-$signed(ty)));
		new_eni = sat_add32(eni_q, e_q);
		new_enj = sat_add32(enj_q, e_q);
		new_total = sat_add32(total_q, e_q);
		px_rd = acc_rd_q[PUSH_W-1:0];
		py_rd = acc_rd_q[2*PUSH_W-1:PUSH_W];
		xj_rd = circ_rd_q[POS_W-1:0];
		yj_rd = circ_rd_q[2*POS_W-1:POS_W];
	end

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_a = '0;
		mul_b = '0;
		sqrt_start = 1'b0;
		sqrt_arg = sq_q + prod_q[SQ_W-1:0];
		div_start = 1'b0;
		div_num = prod_q[NUM_W-1:0] + NUM_W'(len_q[ROOT_W-1:1]);
		circ_we = 1'b0;
		circ_wa = i_q;
		circ_wd = {cr_q, cy_q, cx_q};
		acc_we = 1'b0;
		acc_wa = i_q;
		acc_wd = {eni_q, pyi_q, pxi_q};
		rd_addr = (state_q == S_PAIR_RD) ? j_q : i_q;
		case (state_q)
			S_IDLE: begin
				if (write_go) begin
					circ_we = 1'b1;
					circ_wa = index[IDX_W-1:0];
					circ_wd = {radius, pos_y, pos_x};
				end
				if (run_go) state_d = S_CLR;
			end
			S_CLR: begin
				// clear push and energy of every circle in use
				acc_we = 1'b1;
				acc_wd = '0;
				if (i_q == lastidx_q) state_d = S_ROW_RD;
			end
			S_ROW_RD: state_d = S_ROW_LD;
			S_ROW_LD: state_d = S_MUL_XX;
			S_PAIR_RD: state_d = S_PAIR_LD;
			S_PAIR_LD: state_d = S_MUL_XX;
			S_MUL_XX: begin
				mul_a = MUL_W'(dx_q);
				mul_b = MUL_W'(dx_q);
				state_d = S_MUL_YY;
			end
			S_MUL_YY: begin
				mul_a = MUL_W'(dy_q);
				mul_b = MUL_W'(dy_q);
				state_d = S_SQRT_GO;
			end
			S_SQRT_GO: begin
				sqrt_start = 1'b1;
				state_d = S_SQRT_WAIT;
			end
			S_SQRT_WAIT: begin
				if (sqrt_rsp.done) state_d = S_DEPTH;
			end
			S_DEPTH: begin
				mul_a = depth[MUL_W-1:0];
				mul_b = depth[MUL_W-1:0];
				state_d = S_ENERGY;
			end
			S_ENERGY: state_d = S_MUL_PX;
			S_MUL_PX: begin
				mul_a = MUL_W'(dx_q);
				mul_b = $signed({{(MUL_W-EN_W){1'b0}}, e_q});
				state_d = S_MUL_PY;
			end
			S_MUL_PY: begin
				mul_a = MUL_W'(dy_q);
				mul_b = $signed({{(MUL_W-EN_W){1'b0}}, e_q});
				state_d = S_ACC;
			end
			S_ACC: begin
				if (pair_q) begin
					acc_we = 1'b1;
					acc_wa = j_q;
					acc_wd = {new_enj, new_pyj, new_pxj};
				end
				if ((pair_q && j_q == lastidx_q) || (!pair_q && i_q == lastidx_q))
					state_d = S_ROW_WB;
				else
					state_d = S_PAIR_RD;
			end
			S_ROW_WB: begin
				acc_we = 1'b1;
				if (i_q == lastidx_q) state_d = S_MV_RD;
				else state_d = S_ROW_RD;
			end
			S_MV_RD: state_d = S_MV_LD;
			S_MV_LD: begin
				if (px_rd == '0 && py_rd == '0) state_d = S_MV_OUT;
				else state_d = S_MV_SHIFT;
			end
			S_MV_SHIFT: begin
				// halve both magnitudes until they fit 31 bits
				if (ax_q[PUSH_W-1:ROOT_W-1] == '0 && ay_q[PUSH_W-1:ROOT_W-1] == '0)
					state_d = S_MV_MXX;
			end
			S_MV_MXX: begin
				mul_a = MUL_W'(ax_q[ROOT_W-2:0]);
				mul_b = MUL_W'(ax_q[ROOT_W-2:0]);
				state_d = S_MV_MYY;
			end
			S_MV_MYY: begin
				mul_a = MUL_W'(ay_q[ROOT_W-2:0]);
				mul_b = MUL_W'(ay_q[ROOT_W-2:0]);
				state_d = S_MV_SQRT_GO;
			end
			S_MV_SQRT_GO: begin
				sqrt_start = 1'b1;
				state_d = S_MV_SQRT_WAIT;
			end
			S_MV_SQRT_WAIT: begin
				if (sqrt_rsp.done)
					state_d = (sqrt_rsp.root == '0) ? S_MV_OUT : S_MV_MULX;
			end
			S_MV_MULX: begin
				mul_a = MUL_W'(ax_q[ROOT_W-2:0]);
				mul_b = MUL_W'(step_q);
				state_d = S_MV_DIVX_GO;
			end
			S_MV_DIVX_GO: begin
				div_start = 1'b1;
				state_d = S_MV_DIVX_WAIT;
			end
			S_MV_DIVX_WAIT: begin
				if (div_rsp.done) state_d = S_MV_MULY;
			end
			S_MV_MULY: begin
				mul_a = MUL_W'(ay_q[ROOT_W-2:0]);
				mul_b = MUL_W'(step_q);
				state_d = S_MV_DIVY_GO;
			end
			S_MV_DIVY_GO: begin
				div_start = 1'b1;
				state_d = S_MV_DIVY_WAIT;
			end
			S_MV_DIVY_WAIT: begin
				if (div_rsp.done) state_d = S_MV_OUT;
			end
			S_MV_OUT: begin
				circ_we = 1'b1;
				if (i_q == lastidx_q) state_d = S_IDLE;
				else state_d = S_MV_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- control regs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 7'd1;
			prev_total_q <= START_TOTAL;
			valid <= 1'b0;
		end else begin
			if (cfg_we) count_q <= cfg_data;
			if (state_q == S_ROW_WB && i_q == lastidx_q) prev_total_q <= total_q;
			valid <= (state_q == S_MV_OUT);
		end
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: begin
				if (run_go) begin
					step_q <= step;
					lastidx_q <= IDX_W'(n_eff - 1'b1);
					total_q <= '0;
					i_q <= '0;
				end
			end
			S_CLR: begin
				i_q <= (i_q == lastidx_q) ? '0 : i_q + 1'b1;
			end
			S_ROW_LD: begin
				xi_q <= circ_rd_q[POS_W-1:0];
				yi_q <= circ_rd_q[2*POS_W-1:POS_W];
				ri_q <= circ_rd_q[CIRC_W-1:2*POS_W];
				pxi_q <= px_rd;
				pyi_q <= py_rd;
				eni_q <= acc_rd_q[ACC_W-1:2*PUSH_W];
				dx_q <= $signed(D_W'(ONE_Q16)) - $signed({circ_rd_q[POS_W-1], circ_rd_q[POS_W-1:0]});
				dy_q <= $signed(D_W'(ONE_Q16))
				      - $signed({circ_rd_q[2*POS_W-1], circ_rd_q[2*POS_W-1:POS_W]});
				pair_q <= 1'b0;
			end
			S_PAIR_LD: begin
				rj_q <= circ_rd_q[CIRC_W-1:2*POS_W];
				pxj_q <= px_rd;
				pyj_q <= py_rd;
				enj_q <= acc_rd_q[ACC_W-1:2*PUSH_W];
				dx_q <= $signed({xi_q[POS_W-1], xi_q}) - $signed({xj_rd[POS_W-1], xj_rd});
				dy_q <= $signed({yi_q[POS_W-1], yi_q}) - $signed({yj_rd[POS_W-1], yj_rd});
				pair_q <= 1'b1;
			end
			S_MUL_YY: sq_q <= prod_q[SQ_W-1:0];
			S_SQRT_WAIT: dist_q <= sqrt_rsp.root;
			S_DEPTH: neg_q <= depth[DEP_W-1];
			// a depth of zero or more costs nothing
			S_ENERGY: e_q <= neg_q ? prod_q[EN_W+15:16] : '0;
			S_MUL_PY: tx_q <= prod_q[T_W-1:0];
			S_ACC: begin
				pxi_q <= new_pxi;
				pyi_q <= new_pyi;
				eni_q <= new_eni;
				total_q <= new_total;
				j_q <= pair_q ? j_q + 1'b1 : i_q + 1'b1;
			end
			S_ROW_WB: begin
				if (i_q == lastidx_q) begin
					i_q <= '0;
					drop_q <= {1'b0, prev_total_q} - {1'b0, total_q};
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			S_MV_LD: begin
				cx_q <= circ_rd_q[POS_W-1:0];
				cy_q <= circ_rd_q[2*POS_W-1:POS_W];
				cr_q <= circ_rd_q[CIRC_W-1:2*POS_W];
				mven_q <= acc_rd_q[ACC_W-1:2*PUSH_W];
				sgnx_q <= px_rd[PUSH_W-1];
				sgny_q <= py_rd[PUSH_W-1];
				ax_q <= px_rd[PUSH_W-1] ? PUSH_W'(-px_rd) : px_rd;
				ay_q <= py_rd[PUSH_W-1] ? PUSH_W'(-py_rd) : py_rd;
			end
			S_MV_SHIFT: begin
				if (ax_q[PUSH_W-1:ROOT_W-1] != '0 || ay_q[PUSH_W-1:ROOT_W-1] != '0) begin
					ax_q <= {1'b0, ax_q[PUSH_W-1:1]};
					ay_q <= {1'b0, ay_q[PUSH_W-1:1]};
				end
			end
			S_MV_MYY: sq_q <= prod_q[SQ_W-1:0];
			S_MV_SQRT_WAIT: len_q <= sqrt_rsp.root;
			S_MV_DIVX_WAIT: begin
				if (div_rsp.done) cx_q <= move_pos(cx_q, sgnx_q, div_rsp.quot[Q_W-1:0]);
			end
			S_MV_DIVY_WAIT: begin
				if (div_rsp.done) cy_q <= move_pos(cy_q, sgny_q, div_rsp.quot[Q_W-1:0]);
			end
			S_MV_OUT: begin
				circle_index <= 6'(i_q);
				new_x <= cx_q;
				new_y <= cy_q;
				circle_energy <= mven_q;
				total_energy <= total_q;
				energy_drop <= drop_q;
				last <= (i_q == lastidx_q);
				if (i_q != lastidx_q) i_q <= i_q + 1'b1;
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- memories
	always_ff @(posedge clk) begin
		if (circ_we) circ_mem[circ_wa] <= circ_wd;
		circ_rd_q <= circ_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (acc_we) acc_mem[acc_wa] <= acc_wd;
		acc_rd_q <= acc_mem[rd_addr];
	end

	// ---------------------------------------------------------------- units
	cpog_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sqrt_start),
		.arg   (sqrt_arg),
		.rsp   (sqrt_rsp)
	);

	cpog_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (len_q),
		.rsp   (div_rsp)
	);

	// ---------------------------------------------------------------- checks
	`CPOG_ASSERT_IMP(a_valid_from_out, valid, $past(state_q) == S_MV_OUT, "result without output step")
	`CPOG_ASSERT_NXT(a_run_goes_busy, run_go, busy, "run transfer did not start the sequencer")
	`CPOG_ASSERT_IMP(a_last_ends_run, valid && last, state_q == S_IDLE, "last result but run still going")

endmodule

FILE: dv/circle_packing_overlap_gradient_step_tb.sv
// ----------------------------------------------------------------------------
// circle_packing_overlap_gradient_step_tb
// self-checking bench: circle writes and descent runs are sent through the
// command port, and every strobed circle result is compared with a predictor
// that tracks the circle store, the energies and the previous total
// ----------------------------------------------------------------------------
module circle_packing_overlap_gradient_step_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cpog_pkg::*;

	localparam longint ONE = 65536;
	localparam longint PUSH_HI = 64'sd140737488355327;
	localparam longint PUSH_LO = -64'sd140737488355328;
	localparam longint POS_HI = 524287;
	localparam longint POS_LO = -524288;

	typedef struct {
		logic func;
		logic [5:0] index;
		logic signed [19:0] pos_x;
		logic signed [19:0] pos_y;
		logic [16:0] radius;
		logic [16:0] step;
	} command_t;

	typedef struct {
		logic [5:0] circle_index;
		logic [19:0] new_x;
		logic [19:0] new_y;
		logic [31:0] circle_energy;
		logic [31:0] total_energy;
		logic [32:0] energy_drop;
		logic last;
	} circle_result_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic func;
	logic [5:0] index;
	logic signed [19:0] pos_x;
	logic signed [19:0] pos_y;
	logic [16:0] radius;
	logic [16:0] step;
	logic cfg_we;
	logic [6:0] cfg_data;
	logic valid;
	logic [5:0] circle_index;
	logic signed [19:0] new_x;
	logic signed [19:0] new_y;
	logic [31:0] circle_energy;
	logic [31:0] total_energy;
	logic signed [32:0] energy_drop;
	logic last;

	circle_packing_overlap_gradient_step dut (.*);

	// pending commands and results still owed by the block
	command_t command_queue[$];
	circle_result_t owed_results[$];

	// predictor copy of the block state
	longint centre_x[MAX_CIRCLES];
	longint centre_y[MAX_CIRCLES];
	longint radius_mem[MAX_CIRCLES];
	logic [31:0] last_total;
	logic [6:0] count_reg;

	int issued_cnt;
	int taken_cnt;
	int gap_left;
	bit no_gaps;
	int error_cnt;
	int result_cnt;
	int run_cnt;
	int item_cnt;

	// clock and reset
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#30ms;
		$display("timeout with %0d results still owed", owed_results.size());
		$display("== FAIL ==");
		$finish;
	end

	// arithmetic helpers
	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint distance(input longint dx, input longint dy);
		return longint'(floor_sqrt(longint'(dx * dx) + longint'(dy * dy)));
	endfunction

	// squared penetration depth, zero when clear
	function automatic logic [31:0] overlap_cost(input longint depth);
		longint unsigned sq;
		sq = depth * depth;
		if (depth >= 0)
			return 32'd0;
		return sq >> 16;
	endfunction

	function automatic logic [31:0] energy_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic longint push_add(input longint a, input longint b);
		longint s;
		s = a + b;
		if (s > PUSH_HI)
			return PUSH_HI;
		if (s < PUSH_LO)
			return PUSH_LO;
		return s;
	endfunction

	function automatic longint clamp_pos(input longint v);
		if (v > POS_HI)
			return POS_HI;
		if (v < POS_LO)
			return POS_LO;
		return v;
	endfunction

	// one descent iteration: energies, pushes, moves, owed results
	task automatic predict_iteration(input logic [16:0] stp);
		int n;
		longint px[MAX_CIRCLES];
		longint py[MAX_CIRCLES];
		logic [31:0] en[MAX_CIRCLES];
		logic [31:0] total;
		logic [32:0] drop;
		longint dx, dy, tx, ty, mx, my;
		longint unsigned ax, ay, len;
		logic [31:0] e;
		circle_result_t r;
		n = (count_reg == 0) ? 1 : (count_reg > MAX_CIRCLES) ? MAX_CIRCLES : int'(count_reg);
		total = 0;
		for (int i = 0; i < n; i++) begin
			px[i] = 0;
			py[i] = 0;
			en[i] = 0;
		end
		for (int i = 0; i < n; i++) begin
			// container wall
			dx = ONE - centre_x[i];
			dy = ONE - centre_y[i];
			e = overlap_cost(ONE - (distance(dx, dy) + radius_mem[i]));
			px[i] = push_add(px[i], dx * longint'(e));
			py[i] = push_add(py[i], dy * longint'(e));
			en[i] = energy_add(en[i], e);
			total = energy_add(total, e);
			// every later circle
			for (int j = i + 1; j < n; j++) begin
				dx = centre_x[i] - centre_x[j];
				dy = centre_y[i] - centre_y[j];
				e = overlap_cost(distance(dx, dy) - (radius_mem[i] + radius_mem[j]));
				tx = dx * longint'(e);
				ty = dy * longint'(e);
				px[i] = push_add(px[i], tx);
				py[i] = push_add(py[i], ty);
				px[j] = push_add(px[j], -tx);
				py[j] = push_add(py[j], -ty);
				en[i] = energy_add(en[i], e);
				en[j] = energy_add(en[j], e);
				total = energy_add(total, e);
			end
		end
		drop = {1'b0, last_total} - {1'b0, total};
		last_total = total;
		for (int i = 0; i < n; i++) begin
			if (px[i] != 0 || py[i] != 0) begin
				ax = (px[i] < 0) ? -px[i] : px[i];
				ay = (py[i] < 0) ? -py[i] : py[i];
				while (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
					ax >>= 1;
					ay >>= 1;
				end
				len = floor_sqrt(ax * ax + ay * ay);
				if (len != 0) begin
					mx = longint'((ax * stp + len / 2) / len);
					my = longint'((ay * stp + len / 2) / len);
					centre_x[i] = clamp_pos(centre_x[i] + ((px[i] < 0) ? -mx : mx));
					centre_y[i] = clamp_pos(centre_y[i] + ((py[i] < 0) ? -my : my));
				end
			end
			r.circle_index = i[5:0];
			r.new_x = centre_x[i][19:0];
			r.new_y = centre_y[i][19:0];
			r.circle_energy = en[i];
			r.total_energy = total;
			r.energy_drop = drop;
			r.last = (i == n - 1);
			owed_results.push_back(r);
		end
		run_cnt++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 15);
		if (r < 9)
			return 0;
		if (r < 14)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// driver: one command per transfer, random gaps in between
	always @(negedge clk) begin
		command_t c;
		if (arst_n) begin
			if (!start || taken_cnt == issued_cnt) begin
				if (gap_left > 0 || command_queue.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					start <= 1'b0;
				end else begin
					c = command_queue.pop_front();
					func <= c.func;
					index <= c.index;
					pos_x <= c.pos_x;
					pos_y <= c.pos_y;
					radius <= c.radius;
					step <= c.step;
					start <= 1'b1;
					issued_cnt++;
					gap_left = no_gaps ? 0 : pick_gap();
				end
			end
		end
	end

	// monitor: accept transfers into the predictor, check strobed results
	always @(posedge clk) begin
		circle_result_t x;
		if (arst_n) begin
			if (valid) begin
				if (owed_results.size() == 0) begin
					$error("result for circle %0d with nothing owed", circle_index);
					error_cnt++;
				end else begin
					x = owed_results.pop_front();
					result_cnt++;
					if (circle_index !== x.circle_index) begin
						$error("circle_index exp %0d got %0d", x.circle_index, circle_index);
						error_cnt++;
					end
					if (new_x !== x.new_x) begin
						$error("new_x exp %h got %h", x.new_x, new_x);
						error_cnt++;
					end
					if (new_y !== x.new_y) begin
						$error("new_y exp %h got %h", x.new_y, new_y);
						error_cnt++;
					end
					if (circle_energy !== x.circle_energy) begin
						$error("circle_energy exp %h got %h", x.circle_energy, circle_energy);
						error_cnt++;
					end
					if (total_energy !== x.total_energy) begin
						$error("total_energy exp %h got %h", x.total_energy, total_energy);
						error_cnt++;
					end
					if (energy_drop !== x.energy_drop) begin
						$error("energy_drop exp %h got %h", x.energy_drop, energy_drop);
						error_cnt++;
					end
					if (last !== x.last) begin
						$error("last exp %b got %b", x.last, last);
						error_cnt++;
					end
				end
			end
			if (start && !busy) begin
				taken_cnt++;
				if (func == FUNC_WRITE) begin
					centre_x[index] = longint'(pos_x);
					centre_y[index] = longint'(pos_y);
					radius_mem[index] = longint'(radius);
				end else begin
					predict_iteration(step);
				end
			end
		end
	end

	// stimulus helpers
	task automatic put_circle(input int slot, input int px, input int py, input int rad);
		command_t c;
		c.func = FUNC_WRITE;
		c.index = slot[5:0];
		c.pos_x = px[19:0];
		c.pos_y = py[19:0];
		c.radius = rad[16:0];
		c.step = 17'($urandom);
		command_queue.push_back(c);
		item_cnt++;
	endtask

	task automatic put_run(input int stp);
		command_t c;
		c.func = FUNC_RUN;
		c.index = 6'($urandom);
		c.pos_x = 20'($urandom);
		c.pos_y = 20'($urandom);
		c.radius = 17'($urandom);
		c.step = stp[16:0];
		command_queue.push_back(c);
		item_cnt++;
	endtask

	// circles scattered around the container so overlaps are common
	task automatic put_random_circle(input int slot);
		int r;
		int px, py, rad;
		r = $urandom_range(0, 15);
		if (r == 0) begin
			px = int'(signed'(20'($urandom)));
			py = int'(signed'(20'($urandom)));
		end else begin
			px = $urandom_range(0, 196608) - 32768;
			py = $urandom_range(0, 196608) - 32768;
		end
		r = $urandom_range(0, 15);
		rad = (r == 0) ? $urandom_range(65536, 131071) : (r == 1) ? 65536 :
			$urandom_range(0, 45000);
		put_circle(slot, px, py, rad);
	endtask

	function automatic int random_step();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return $urandom_range(0, 131071);
		return $urandom_range(0, 65536);
	endfunction

	// block idle: no command pending, nothing owed, then room for a trailing write
	task automatic wait_quiet();
		do
			@(posedge clk);
		while (command_queue.size() != 0 || start || busy || owed_results.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_count(input logic [6:0] v);
		wait_quiet();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		count_reg = v;
	endtask

	initial begin
		int n;
		int r;
		start = 1'b0;
		func = FUNC_WRITE;
		index = '0;
		pos_x = '0;
		pos_y = '0;
		radius = '0;
		step = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		count_reg = 7'd1;
		last_total = START_TOTAL;
		for (int i = 0; i < MAX_CIRCLES; i++) begin
			centre_x[i] = 0;
			centre_y[i] = 0;
			radius_mem[i] = 0;
		end
		@(posedge arst_n);

		// directed: corner positions and radii, far outside and oversized
		set_count(7'd2);
		put_circle(0, 524287, -524288, 65536);
		put_circle(1, 65536, 65536, 131071);
		put_run(65536);
		// count zero acts as one, zero step
		set_count(7'd0);
		put_run(0);
		// three circles: two stacked on one spot inside the wall, one clear
		set_count(7'd3);
		put_circle(0, 60000, 60000, 30000);
		put_circle(1, 60000, 60000, 30000);
		put_circle(2, 90000, 70000, 0);
		put_run(32768);
		put_run(131071);
		// a lone circle at the centre feels no push and stays put
		set_count(7'd1);
		put_circle(0, 65536, 65536, 20000);
		put_run(65536);
		put_circle(0, -524288, 524287, 0);
		put_run(1);

		// random phases: fresh circle set, a few runs, new count between phases
		while (item_cnt < 230) begin
			r = $urandom_range(0, 15);
			if (run_cnt == 8)
				set_count(7'd64);
			else if (run_cnt == 20)
				set_count(7'd127);
			else if (r == 0)
				set_count(7'd0);
			else
				set_count(7'($urandom_range(1, 8)));
			no_gaps = ($urandom_range(0, 3) == 0);
			n = (count_reg == 0) ? 1 : (count_reg > MAX_CIRCLES) ? MAX_CIRCLES : count_reg;
			for (int i = 0; i < n; i++)
				put_random_circle(i);
			// noise: a write to a slot outside the count, or to any slot when all are in use
			if ($urandom_range(0, 3) == 0)
				put_random_circle($urandom_range(n == MAX_CIRCLES ? 0 : n, 63));
			r = (n > 8) ? 1 : $urandom_range(1, 3);
			for (int k = 0; k < r; k++)
				put_run(random_step());
		end

		wait_quiet();
		repeat (50) @(posedge clk);
		$display("%0d commands sent, %0d descent runs, %0d circle results checked",
			item_cnt, run_cnt, result_cnt);
		if (error_cnt == 0 && owed_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d results never seen", error_cnt, owed_results.size());
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		issued_cnt = 0;
		taken_cnt = 0;
		gap_left = 0;
		no_gaps = 0;
		error_cnt = 0;
		result_cnt = 0;
		run_cnt = 0;
		item_cnt = 0;
	end

endmodule

FILE: circle_packing_overlap_gradient_step.f
+incdir+sv
sv/cpog_pkg.sv
sv/cpog_sqrt.sv
sv/cpog_div.sv
sv/circle_packing_overlap_gradient_step.sv
dv/circle_packing_overlap_gradient_step_tb.sv
